FILE: rtl/dtsg_pkg.sv
// Package for the decaying tone sample generator: widths, codes, reset values,
// the controller/datapath command and status structs, and the sine table builder.
// No dependencies.
package dtsg_pkg;

	localparam int PHASE_STEPS = 2205;
	localparam int SINE_PEAK   = 32767;
	localparam int PHASE_W     = $clog2(PHASE_STEPS);
	localparam int ROM_W       = 16;

	localparam int MODE_W      = 2;
	localparam int PORT_W      = 8;
	localparam int TICKS_W     = 10;
	localparam int SPF_W       = 10;
	localparam int PERIOD_W    = 16;
	localparam int ACC_W       = 17;
	localparam int POS_W       = 10;
	localparam int AMP_W       = 15;
	localparam int SAMPLE_W    = 15;
	localparam int RUN_W       = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int TONE_VAL_W  = ROM_W + 2;
	localparam int PROD_W      = 31;
	localparam int MAG_W       = PROD_W - 1;
	localparam int DIV_RECIP_W = 31;
	localparam int QUOT_W      = MAG_W + DIV_RECIP_W;
	localparam int DIV_SHIFT   = 47;
	localparam int Q_W         = 14;
	localparam int DEC_Y_W     = 24;
	localparam int DEC_RECIP_W = 25;
	localparam int DEC_FULL_W  = DEC_Y_W + DEC_RECIP_W;
	localparam int DEC_SHIFT   = 34;

	localparam logic [SPF_W-1:0]       SPF_RESET    = 10'd735;
	localparam logic [PERIOD_W-1:0]    PERIOD_RESET = 16'd2029;
	localparam logic [AMP_W-1:0]       FULL_AMP     = 15'd16384;
	localparam logic [ACC_W-1:0]       ACC_MAX      = 17'h1FFFF;
	localparam logic [POS_W-1:0]       POS_MAX      = 10'd1023;
	localparam logic [6:0]             TICK_SCALE   = 7'd100;
	localparam logic [RUN_W-1:0]       MAX_RUN      = 6'd51;
	localparam logic [PORT_W-1:0]      TONE_PORT    = 8'd5;
	localparam logic [9:0]             DECAY_NUM    = 10'd998;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP    = 31'd1407374884;
	localparam logic [DEC_RECIP_W-1:0] DEC_RECIP    = 25'd17179870;

	localparam int STEP_X50 = 50;
	localparam int STEP_X25 = 25;
	localparam int STEP_X6  = 6;
	localparam int STEP_X12 = 12;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPF    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD = 2'd1;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [MODE_W-1:0] {
		MODE_PORT       = 2'd0,
		MODE_TICKS      = 2'd1,
		MODE_FRAME      = 2'd2,
		MODE_SOFT_RESET = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		TONE_SILENT = 2'd0,
		TONE_X50    = 2'd1,
		TONE_X25    = 2'd2,
		TONE_MIX    = 2'd3
	} tone_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ_A,
		ST_READ_B,
		ST_SUM,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic apply_port;
		logic frame_clear;
		logic soft_reset;
		logic add_ticks;
		logic take;
		logic rom_second;
		logic cap_a;
		logic sum;
		logic mul;
		logic div;
		logic emit;
		logic last;
	} ctrl_t;

	typedef struct packed {
		logic more;
		logic out_free;
	} status_t;

	typedef logic signed [ROM_W-1:0] sine_table_t [PHASE_STEPS];

	function automatic logic [PHASE_W-1:0] phase_step(input logic [PHASE_W-1:0] idx,
			input int step);
		logic [PHASE_W:0] sum;
		sum = {1'b0, idx} + (PHASE_W+1)'(step);
		if (sum >= (PHASE_W+1)'(PHASE_STEPS))
			sum = sum - (PHASE_W+1)'(PHASE_STEPS);
		return sum[PHASE_W-1:0];
	endfunction

	function automatic sine_table_t build_sine();
		sine_table_t t;
		longint unsigned u, quad, r, th, x2, h, s, v;
		for (int i = 0; i < PHASE_STEPS; i++) begin
			u = 64'(4 * i);
			quad = u / PHASE_STEPS;
			r = u % PHASE_STEPS;
			if (quad[0])
				r = 64'(PHASE_STEPS) - r;
			th = r * HALF_PI_Q30 / PHASE_STEPS;
			x2 = (th * th) >> 30;
			h = Q30_ONE;
			h = Q30_ONE - ((x2 * h) >> 30) / 110;
			h = Q30_ONE - ((x2 * h) >> 30) / 72;
			h = Q30_ONE - ((x2 * h) >> 30) / 42;
			h = Q30_ONE - ((x2 * h) >> 30) / 20;
			h = Q30_ONE - ((x2 * h) >> 30) / 6;
			s = (th * h) >> 30;
			v = (s * 64'(SINE_PEAK) + 64'h2000_0000) >> 30;
			if (v > 64'(SINE_PEAK))
				v = 64'(SINE_PEAK);
			if (quad >= 2)
				t[i] = -$signed(ROM_W'(v));
			else
				t[i] = $signed(ROM_W'(v));
		end
		return t;
	endfunction

endpackage

FILE: rtl/dtsg_item_if.sv
// Request channel of the tone generator: valid/ready plus the request fields.
// Depends on dtsg_pkg.
interface dtsg_item_if;
	import dtsg_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [PORT_W-1:0]   port_number;
	logic [PORT_W-1:0]   port_value;
	logic [TICKS_W-1:0]  elapsed_ticks;

	modport source (output valid, mode, port_number, port_value, elapsed_ticks, input ready);
	modport sink   (input valid, mode, port_number, port_value, elapsed_ticks, output ready);
endinterface

FILE: rtl/dtsg_result_if.sv
// Sample channel of the tone generator: valid/ready plus one audio sample.
// Depends on dtsg_pkg.
interface dtsg_result_if;
	import dtsg_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic [POS_W-1:0]           sample_position;
	logic                       in_frame;
	logic                       last_of_run;

	modport source (output valid, sample_value, sample_position, in_frame, last_of_run,
		input ready);
	modport sink   (input valid, sample_value, sample_position, in_frame, last_of_run,
		output ready);
endinterface

FILE: rtl/dtsg_cfg_if.sv
// Register write channel of the tone generator: valid/ready, index and data.
// Depends on dtsg_pkg.
interface dtsg_cfg_if;
	import dtsg_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dtsg_sine_rom.sv
// Sine table with a registered read port.
// Depends on dtsg_pkg for the table contents and widths.
module dtsg_sine_rom (
	input  logic                              clk,
	input  logic [dtsg_pkg::PHASE_W-1:0]      addr,
	output logic signed [dtsg_pkg::ROM_W-1:0] data
);
	import dtsg_pkg::*;

	localparam sine_table_t SINE_TABLE = build_sine();

	logic signed [ROM_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= SINE_TABLE[addr];
	end

	assign data = data_q;
endmodule

FILE: rtl/dtsg_ctrl.sv
// Controller of the tone generator: request decode and the per-sample sequence.
// Depends on dtsg_pkg; drives the datapath through ctrl_t, reads status_t.
module dtsg_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic [dtsg_pkg::MODE_W-1:0] item_mode,
	output logic                        item_ready,
	input  dtsg_pkg::status_t           sts,
	output dtsg_pkg::ctrl_t             ctl
);
	import dtsg_pkg::*;

	state_t           state_q, state_d;
	logic [RUN_W-1:0] run_q;
	logic             run_go;

	assign run_go = (run_q < MAX_RUN) && sts.more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				run_q <= '0;
			else if (ctl.take)
				run_q <= run_q + RUN_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && mode_t'(item_mode) == MODE_TICKS)
					state_d = ST_CHECK;
			end
			ST_CHECK:  state_d = run_go ? ST_READ_A : ST_IDLE;
			ST_READ_A: state_d = ST_READ_B;
			ST_READ_B: state_d = ST_SUM;
			ST_SUM:    state_d = ST_MUL;
			ST_MUL:    state_d = ST_DIV;
			ST_DIV:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free)
					state_d = ST_CHECK;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (mode_t'(item_mode))
						MODE_PORT:       ctl.apply_port  = 1'b1;
						MODE_TICKS:      ctl.add_ticks   = 1'b1;
						MODE_FRAME:      ctl.frame_clear = 1'b1;
						MODE_SOFT_RESET: ctl.soft_reset  = 1'b1;
						default:         ctl.apply_port  = 1'b0;
					endcase
				end
			end
			ST_CHECK:  ctl.take = run_go;
			ST_READ_A: ctl.rom_second = 1'b0;
			ST_READ_B: begin
				ctl.rom_second = 1'b1;
				ctl.cap_a      = 1'b1;
			end
			ST_SUM:    ctl.sum = 1'b1;
			ST_MUL:    ctl.mul = 1'b1;
			ST_DIV:    ctl.div = 1'b1;
			ST_EMIT: begin
				ctl.emit = sts.out_free;
				ctl.last = (run_q == MAX_RUN) || !sts.more;
			end
			default:   ctl = '0;
		endcase
	end
endmodule

FILE: rtl/dtsg_datapath.sv
// Datapath of the tone generator: tone state, tick accumulator, sine lookup,
// amplitude scaling and decay, output register. Depends on dtsg_pkg, dtsg_sine_rom.
module dtsg_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dtsg_pkg::ctrl_t                       ctl,
	output dtsg_pkg::status_t                     sts,
	input  logic [dtsg_pkg::PORT_W-1:0]           port_number,
	input  logic [dtsg_pkg::PORT_W-1:0]           port_value,
	input  logic [dtsg_pkg::TICKS_W-1:0]          elapsed_ticks,
	input  logic                                  cfg_write,
	input  logic [dtsg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dtsg_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic signed [dtsg_pkg::SAMPLE_W-1:0]  res_sample_value,
	output logic [dtsg_pkg::POS_W-1:0]            res_sample_position,
	output logic                                  res_in_frame,
	output logic                                  res_last_of_run
);
	import dtsg_pkg::*;

	logic [SPF_W-1:0]    spf_q;
	logic [PERIOD_W-1:0] period_q;
	tone_t               tone_q;
	logic [AMP_W-1:0]    amp_q;
	logic [ACC_W-1:0]    acc_q;
	logic [POS_W-1:0]    pos_q;
	logic [PHASE_W-1:0]  idx50_q, idx25_q, idx6_q, idx12_q;
	logic                inside_q;

	logic [PHASE_W-1:0]           rom_addr;
	logic signed [ROM_W-1:0]      rom_data;
	logic signed [ROM_W-1:0]      rom_a_q;
	logic signed [TONE_VAL_W-1:0] tone_val_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic                         neg_q;
	logic [QUOT_W-1:0]            quot_q;
	logic [DEC_Y_W-1:0]           dec_y_q;
	logic [DEC_FULL_W-1:0]        dec_full_q;

	logic                         out_valid_q;
	logic signed [SAMPLE_W-1:0]   out_value_q;
	logic [POS_W-1:0]             out_pos_q;
	logic                         out_in_frame_q;
	logic                         out_last_q;

	logic [ACC_W:0]               acc_sum;
	tone_t                        tone_new;
	logic signed [TONE_VAL_W-1:0] rom_a_ext, rom_b_ext, tone_sel;
	logic signed [PROD_W-1:0]     tone_wide, amp_wide, prod_d;
	logic [MAG_W-1:0]             mag;
	logic [Q_W-1:0]               quot;
	logic signed [SAMPLE_W-1:0]   quot_s;

	assign acc_sum  = {1'b0, acc_q} + (ACC_W+1)'(elapsed_ticks) * (ACC_W+1)'(TICK_SCALE);
	assign tone_new = tone_t'(port_value[7:6]);

	assign sts.more     = acc_q > {1'b0, period_q};
	assign sts.out_free = !out_valid_q || res_ready;

	always_comb begin
		if (ctl.rom_second)
			rom_addr = idx12_q;
		else begin
			case (tone_q)
				TONE_X50: rom_addr = idx50_q;
				TONE_X25: rom_addr = idx25_q;
				default:  rom_addr = idx6_q;
			endcase
		end
	end

	dtsg_sine_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign rom_a_ext = TONE_VAL_W'(rom_a_q);
	assign rom_b_ext = TONE_VAL_W'(rom_data);

	always_comb begin
		case (tone_q)
			TONE_X50: tone_sel = rom_a_ext + rom_a_ext;
			TONE_X25: tone_sel = rom_a_ext + rom_a_ext;
			TONE_MIX: tone_sel = rom_a_ext + rom_b_ext;
			default:  tone_sel = '0;
		endcase
	end

	assign tone_wide = PROD_W'(tone_val_q);
	assign amp_wide  = PROD_W'({1'b0, amp_q});
	assign prod_d    = tone_wide * amp_wide;
	assign mag       = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
	assign quot      = quot_q[DIV_SHIFT +: Q_W];
	assign quot_s    = SAMPLE_W'(quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spf_q    <= SPF_RESET;
			period_q <= PERIOD_RESET;
			tone_q   <= TONE_SILENT;
			amp_q    <= FULL_AMP;
			acc_q    <= '0;
			pos_q    <= '0;
			idx50_q  <= '0;
			idx25_q  <= '0;
			idx6_q   <= '0;
			idx12_q  <= '0;
		end else begin
			if (cfg_write && cfg_index == CFG_SPF)
				spf_q <= cfg_data[SPF_W-1:0];
			if (cfg_write && cfg_index == CFG_PERIOD)
				period_q <= cfg_data[PERIOD_W-1:0];

			if (ctl.apply_port && port_number == TONE_PORT && tone_new != tone_q) begin
				tone_q  <= tone_new;
				amp_q   <= FULL_AMP;
				idx50_q <= '0;
				idx25_q <= '0;
				idx6_q  <= '0;
				idx12_q <= '0;
			end
			if (ctl.frame_clear)
				pos_q <= '0;
			if (ctl.soft_reset) begin
				pos_q  <= '0;
				tone_q <= TONE_SILENT;
			end
			if (ctl.add_ticks)
				acc_q <= (acc_sum > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
			if (ctl.take)
				acc_q <= acc_q - ACC_W'(period_q);
			if (ctl.emit) begin
				amp_q   <= dec_full_q[DEC_SHIFT +: AMP_W];
				pos_q   <= (pos_q < POS_MAX) ? pos_q + POS_W'(1) : pos_q;
				idx50_q <= phase_step(idx50_q, STEP_X50);
				idx25_q <= phase_step(idx25_q, STEP_X25);
				idx6_q  <= phase_step(idx6_q, STEP_X6);
				idx12_q <= phase_step(idx12_q, STEP_X12);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take)
			inside_q <= pos_q < spf_q;
		if (ctl.cap_a)
			rom_a_q <= rom_data;
		if (ctl.sum)
			tone_val_q <= inside_q ? tone_sel : '0;
		if (ctl.mul) begin
			prod_q  <= prod_d;
			dec_y_q <= DEC_Y_W'(amp_q) * DEC_Y_W'(DECAY_NUM);
		end
		if (ctl.div) begin
			neg_q      <= prod_q[PROD_W-1];
			quot_q     <= QUOT_W'(mag) * QUOT_W'(DIV_RECIP);
			dec_full_q <= DEC_FULL_W'(dec_y_q) * DEC_FULL_W'(DEC_RECIP);
		end
		if (ctl.emit) begin
			out_value_q    <= neg_q ? -quot_s : quot_s;
			out_pos_q      <= pos_q;
			out_in_frame_q <= inside_q;
			out_last_q     <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.emit)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	assign res_valid           = out_valid_q;
	assign res_sample_value    = out_value_q;
	assign res_sample_position = out_pos_q;
	assign res_in_frame        = out_in_frame_q;
	assign res_last_of_run     = out_last_q;
endmodule

FILE: rtl/decaying_tone_sample_generator.sv
// Top level of the decaying tone sample generator: controller plus datapath.
// Depends on dtsg_pkg, the three channel interfaces, dtsg_ctrl and dtsg_datapath.
//
// Channels: item takes requests (port write, elapsed ticks, frame start, soft
// reset); result gives audio samples; cfg writes samples_per_frame (index 0) and
// sample_period (index 1) and is always ready.
// A port write, frame start or soft reset request gives no sample. A tick request
// adds ticks*100 to the accumulator and then gives zero to 51 samples, the last
// one flagged with last_of_run. Each sample passes through the controller
// sequence: a period check, two reads of the single sine ROM port, a sum, the
// amplitude multiply, the reciprocal multiply for the /100000 and /1000
// scalings, and the load into the output register. No request is taken until
// the run of a tick request is over.
// The output register holds one sample; while the receiver stalls, the sequence
// waits in its last step and resumes the cycle the register is taken.
// Reset: silent tone, full amplitude, phase, accumulator and position zero,
// registers at 735 and 2029. The sine table is constant; no clearing pass.
module decaying_tone_sample_generator (
	input logic             clk,
	input logic             arst_n,
	dtsg_item_if.sink       item,
	dtsg_result_if.source   result,
	dtsg_cfg_if.sink        cfg
);
	import dtsg_pkg::*;

	ctrl_t   ctl;
	status_t sts;

	assign cfg.ready = 1'b1;

	dtsg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_mode  (item.mode),
		.item_ready (item.ready),
		.sts        (sts),
		.ctl        (ctl)
	);

	dtsg_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ctl                 (ctl),
		.sts                 (sts),
		.port_number         (item.port_number),
		.port_value          (item.port_value),
		.elapsed_ticks       (item.elapsed_ticks),
		.cfg_write           (cfg.valid),
		.cfg_index           (cfg.index),
		.cfg_data            (cfg.data),
		.res_valid           (result.valid),
		.res_ready           (result.ready),
		.res_sample_value    (result.sample_value),
		.res_sample_position (result.sample_position),
		.res_in_frame        (result.in_frame),
		.res_last_of_run     (result.last_of_run)
	);

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> sts.out_free)
		else $error("sample loaded over a pending sample");

	a_out_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.in_frame |-> result.sample_value == '0)
		else $error("out-of-frame sample is not zero");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.apply_port, ctl.frame_clear, ctl.soft_reset, ctl.add_ticks,
			ctl.take, ctl.emit}))
		else $error("conflicting datapath commands");

	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> !item.ready)
		else $error("request taken during a sample run");
`endif
endmodule
